@@ src/spor_pkg.sv @@
// spor_pkg: shared constants for the slot pool with oldest-slot reclaim.
// No dependencies; used by slot_pool_oldest_reclaim and spor_age_ram.
package spor_pkg;

  // Request codes carried on the op field
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Width of the slot fields on the ports
  localparam int unsigned SLOT_PORT_W = 4;

  // Free-slot search looks at this many active bits per cycle
  localparam int unsigned CHUNK_LG   = 4;
  localparam int unsigned CHUNK_BITS = 1 << CHUNK_LG;

  // Read latency of the age list memory, in cycles
  localparam int unsigned RAM_RD_LAT = 1;

endpackage

@@ src/spor_age_ram.sv @@
// spor_age_ram: one-write, one-read synchronous memory for the age list.
// Registered read data (read register sized by spor_pkg::RAM_RD_LAT).
module spor_age_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r [spor_pkg::RAM_RD_LAT];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    rd_data_r[0] <= mem[rd_addr];
  end

  assign rd_data = rd_data_r[0];

endmodule

@@ src/slot_pool_oldest_reclaim.sv @@
// slot_pool_oldest_reclaim: slot pool with active bits and an age-ordered grant list.
// Depends on spor_pkg and spor_age_ram (the age list, kept as a circular buffer).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_op, in_slot_in   | request
//   out     | out_valid, out_stall, out_slot_out,     | response
//           | out_granted, out_recycled               |
//
// Allocate passes S_FIND once per 16-slot group scanned for a free slot, then S_DONE;
// a reclaim (pool full) passes S_RECL, then S_DONE. Release of a listed slot walks the list
// through the single memory read port in S_REL; other releases go straight to S_DONE.
// Synchronous active-low reset empties the pool; the list memory needs no clearing.
// A new request is taken once the previous one is parked in the output register,
// so out_stall only holds back a request after the one still waiting.
module slot_pool_oldest_reclaim #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [3:0] in_slot_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_slot_out,
  output logic       out_granted,
  output logic       out_recycled
);

  localparam int unsigned SLOT_W   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(POOL_SLOTS + 1);
  localparam int unsigned NCHUNK   =
    (POOL_SLOTS + spor_pkg::CHUNK_BITS - 1) / spor_pkg::CHUNK_BITS;
  localparam int unsigned CH_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PAD_BITS = NCHUNK * spor_pkg::CHUNK_BITS;
  localparam int unsigned PW       = spor_pkg::SLOT_PORT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_RECL = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [POOL_SLOTS-1:0] active_r, active_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [SLOT_W-1:0]     off_r, off_nxt;
  logic [CH_W-1:0]       chunk_r, chunk_nxt;
  logic                  found_r, found_nxt;
  logic [SLOT_W-1:0]     req_idx_r, req_idx_nxt;
  logic [PW-1:0]         res_slot_r, res_slot_nxt;
  logic                  res_granted_r, res_granted_nxt;
  logic                  res_recycled_r, res_recycled_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PW-1:0]         out_slot_r, out_slot_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic                  out_recycled_r, out_recycled_nxt;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_wr_addr;
  logic [SLOT_W-1:0]     ram_wr_data;
  logic [SLOT_W-1:0]     ram_rd_addr;
  logic [SLOT_W-1:0]     ram_rd_data;

  logic [PAD_BITS-1:0]             active_pad;
  logic [spor_pkg::CHUNK_BITS-1:0] free_vec;
  logic [spor_pkg::CHUNK_LG-1:0]   pick_idx;
  logic                            pick_hit;
  logic [SLOT_W-1:0]               pick_slot;
  logic [SLOT_W-1:0]               in_idx;
  logic                            in_range;
  logic [CNT_W-1:0]                count_m1;
  logic                            accept;
  logic                            out_free;

  // Add a list offset to a physical position, wrapping around the pool
  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] ofs);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (SLOT_W+1)'(POOL_SLOTS)) begin
      sum = sum - (SLOT_W+1)'(POOL_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  spor_age_ram #(
    .DEPTH (POOL_SLOTS),
    .AW    (SLOT_W),
    .DW    (SLOT_W)
  ) u_age_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && (state_r == S_IDLE);
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_slot_out = out_slot_r;
  assign out_granted  = out_granted_r;
  assign out_recycled = out_recycled_r;

  assign in_idx   = SLOT_W'(in_slot_in);
  assign in_range = (32'(in_slot_in) < 32'(POOL_SLOTS));
  assign count_m1 = count_r - CNT_W'(1);

  // Pad the active bits to whole groups; slots past the pool read as taken
  always_comb begin
    active_pad = '1;
    active_pad[POOL_SLOTS-1:0] = active_r;
  end

  // Lowest free slot within the current group
  always_comb begin
    free_vec = ~active_pad[chunk_r * spor_pkg::CHUNK_BITS +: spor_pkg::CHUNK_BITS];
    pick_idx = '0;
    pick_hit = 1'b0;
    for (int b = spor_pkg::CHUNK_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        pick_idx = spor_pkg::CHUNK_LG'(b);
        pick_hit = 1'b1;
      end
    end
    pick_slot = SLOT_W'({chunk_r, pick_idx});
  end

  // Request sequencer
  always_comb begin
    state_nxt        = state_r;
    active_nxt       = active_r;
    count_nxt        = count_r;
    head_nxt         = head_r;
    off_nxt          = off_r;
    chunk_nxt        = chunk_r;
    found_nxt        = found_r;
    req_idx_nxt      = req_idx_r;
    res_slot_nxt     = res_slot_r;
    res_granted_nxt  = res_granted_r;
    res_recycled_nxt = res_recycled_r;
    out_valid_nxt    = out_valid_r;
    out_slot_nxt     = out_slot_r;
    out_granted_nxt  = out_granted_r;
    out_recycled_nxt = out_recycled_r;
    ram_we           = 1'b0;
    ram_wr_addr      = '0;
    ram_wr_data      = '0;
    ram_rd_addr      = head_r;

    // Drop the output beat once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_recycled_nxt = 1'b0;
          res_granted_nxt  = 1'b0;
          if (in_op == spor_pkg::OP_ALLOC) begin
            res_slot_nxt = '0;
            chunk_nxt    = '0;
            if (count_r == CNT_W'(POOL_SLOTS)) begin
              state_nxt = S_RECL;
            end else begin
              state_nxt = S_FIND;
            end
          end else begin
            res_slot_nxt = in_slot_in;
            req_idx_nxt  = in_idx;
            off_nxt      = '0;
            found_nxt    = 1'b0;
            if (!in_range) begin
              state_nxt = S_DONE;
            end else begin
              active_nxt[in_idx] = 1'b0;
              if (active_r[in_idx]) begin
                state_nxt = S_REL;
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
        end
      end

      S_FIND: begin
        if (pick_hit) begin
          active_nxt[pick_slot] = 1'b1;
          ram_we          = 1'b1;
          ram_wr_addr     = wrap_add(head_r, SLOT_W'(count_r));
          ram_wr_data     = pick_slot;
          count_nxt       = count_r + CNT_W'(1);
          res_slot_nxt    = PW'(pick_slot);
          res_granted_nxt = 1'b1;
          state_nxt       = S_DONE;
        end else if (chunk_r == CH_W'(NCHUNK - 1)) begin
          state_nxt = S_DONE;
        end else begin
          chunk_nxt = chunk_r + CH_W'(1);
        end
      end

      S_RECL: begin
        // Full list: the oldest moves to the tail by advancing the head
        res_slot_nxt     = PW'(ram_rd_data);
        res_granted_nxt  = 1'b1;
        res_recycled_nxt = 1'b1;
        head_nxt         = wrap_add(head_r, SLOT_W'(1));
        state_nxt        = S_DONE;
      end

      S_REL: begin
        // Walk the list; after the match, shift each later entry down one
        found_nxt = found_r || (ram_rd_data == req_idx_r);
        if (found_r) begin
          ram_we      = 1'b1;
          ram_wr_addr = wrap_add(head_r, off_r - SLOT_W'(1));
          ram_wr_data = ram_rd_data;
        end
        if (off_r == SLOT_W'(count_m1)) begin
          if (found_nxt) begin
            count_nxt = count_m1;
          end
          res_granted_nxt = found_nxt;
          state_nxt       = S_DONE;
        end else begin
          off_nxt     = off_r + SLOT_W'(1);
          ram_rd_addr = wrap_add(head_r, off_r + SLOT_W'(1));
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_slot_nxt     = res_slot_r;
          out_granted_nxt  = res_granted_r;
          out_recycled_nxt = res_recycled_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    off_r          <= off_nxt;
    chunk_r        <= chunk_nxt;
    found_r        <= found_nxt;
    req_idx_r      <= req_idx_nxt;
    res_slot_r     <= res_slot_nxt;
    res_granted_r  <= res_granted_nxt;
    res_recycled_r <= res_recycled_nxt;
    out_slot_r     <= out_slot_nxt;
    out_granted_r  <= out_granted_nxt;
    out_recycled_r <= out_recycled_nxt;
  end

endmodule

@@ sim/spor_grant_monitor.sv @@
// spor_grant_monitor: watches both channels of slot_pool_oldest_reclaim, predicts
// every grant from its own copy of the pool and age list, and counts mismatches.
// Depends on spor_pkg for the request codes and the slot field width.
module spor_grant_monitor #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_op,
  input  logic [spor_pkg::SLOT_PORT_W-1:0] in_slot_in,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [spor_pkg::SLOT_PORT_W-1:0] out_slot_out,
  input  logic                             out_granted,
  input  logic                             out_recycled,
  output int                               fail_count,
  output int                               pending,
  output int                               recycle_seen,
  output int                               release_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [spor_pkg::SLOT_PORT_W-1:0] slot;
    logic                             granted;
    logic                             recycled;
  } grant_t;

  // Shadow pool: busy bits and the grant order, oldest first
  logic                             slot_busy [POOL_SLOTS];
  logic [spor_pkg::SLOT_PORT_W-1:0] age_order [POOL_SLOTS];
  int                               age_len;

  grant_t grants_due [$];
  int     fails    = 0;
  int     due_cnt  = 0;
  int     recycles = 0;
  int     rel_hits = 0;

  assign fail_count   = fails;
  assign pending      = due_cnt;
  assign recycle_seen = recycles;
  assign release_hits = rel_hits;

  // Append a slot at the young end; drop when the list is already full
  task automatic list_push(input logic [spor_pkg::SLOT_PORT_W-1:0] slot);
    if (age_len < POOL_SLOTS) begin
      age_order[age_len] = slot;
      age_len++;
    end
  endtask

  // Remove the entry at pos and close the gap
  task automatic list_drop(input int pos);
    int k;
    for (k = pos; k + 1 < age_len; k++)
      age_order[k] = age_order[k + 1];
    age_len--;
  endtask

  // Advance the shadow pool by one request and work out its grant
  task automatic pool_apply(input logic op, input logic [spor_pkg::SLOT_PORT_W-1:0] slot,
                            output grant_t g);
    int                               k;
    logic                             found;
    logic [spor_pkg::SLOT_PORT_W-1:0] oldest;
    g = '0;
    if (op == spor_pkg::OP_ALLOC) begin
      found = 1'b0;
      for (k = 0; k < POOL_SLOTS; k++) begin
        if (!found && !slot_busy[k]) begin
          slot_busy[k] = 1'b1;
          list_push(k[spor_pkg::SLOT_PORT_W-1:0]);
          g.slot    = k[spor_pkg::SLOT_PORT_W-1:0];
          g.granted = 1'b1;
          found     = 1'b1;
        end
      end
      // Pool full: reclaim the oldest slot and move it to the young end
      if (!found && age_len > 0) begin
        oldest = age_order[0];
        list_drop(0);
        list_push(oldest);
        g.slot     = oldest;
        g.granted  = 1'b1;
        g.recycled = 1'b1;
      end
    end else begin
      g.slot = slot;
      if (slot < POOL_SLOTS) begin
        k = 0;
        while (k < age_len) begin
          if (age_order[k] == slot) begin
            list_drop(k);
            g.granted = 1'b1;
          end else begin
            k++;
          end
        end
        slot_busy[slot] = 1'b0;
      end
    end
  endtask

  // Check the result beat first: it always belongs to an earlier request
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        age_order[i] = '0;
      end
      age_len = 0;
      grants_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{slot: out_slot_out, granted: out_granted, recycled: out_recycled};
        if (grants_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat slot=%0d granted=%0b recycled=%0b",
                   $time, got.slot, got.granted, got.recycled);
        end else begin
          want = grants_due.pop_front();
          if (got.slot !== want.slot || got.granted !== want.granted ||
              got.recycled !== want.recycled) begin
            fails++;
            $display("%0t: mismatch, expected slot=%0d granted=%0b recycled=%0b,",
                     $time, want.slot, want.granted, want.recycled,
                     " got slot=%0d granted=%0b recycled=%0b",
                     got.slot, got.granted, got.recycled);
          end
          if (want.recycled)
            recycles++;
        end
      end
      if (in_valid && !in_stall) begin
        pool_apply(in_op, in_slot_in, want);
        if (in_op == spor_pkg::OP_RELEASE && want.granted)
          rel_hits++;
        grants_due.push_back(want);
      end
    end
    due_cnt = grants_due.size();
  end

endmodule

@@ sim/testbench.sv @@
// testbench: drives request beats into slot_pool_oldest_reclaim with random idling
// and back-pressure; spor_grant_monitor does all prediction and checking.
// Depends on spor_pkg, slot_pool_oldest_reclaim and spor_grant_monitor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL = 16;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 630;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_valid   = 1'b0;
  logic                             in_stall;
  logic                             in_op      = spor_pkg::OP_ALLOC;
  logic [spor_pkg::SLOT_PORT_W-1:0] in_slot_in = '0;
  logic                             out_valid;
  logic                             out_stall  = 1'b0;
  logic [spor_pkg::SLOT_PORT_W-1:0] out_slot_out;
  logic                             out_granted;
  logic                             out_recycled;

  int fail_count, pending, recycle_seen, release_hits;
  int send_idle  = 0;
  int recv_idle  = 0;
  int hold_req   = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int beats_sent = 0;
  int quiet      = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  slot_pool_oldest_reclaim #(.POOL_SLOTS(POOL)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_slot_in   (in_slot_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot_out (out_slot_out),
    .out_granted  (out_granted),
    .out_recycled (out_recycled)
  );

  spor_grant_monitor #(.POOL_SLOTS(POOL)) grant_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_slot_in   (in_slot_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot_out (out_slot_out),
    .out_granted  (out_granted),
    .out_recycled (out_recycled),
    .fail_count   (fail_count),
    .pending      (pending),
    .recycle_seen (recycle_seen),
    .release_hits (release_hits)
  );

  // Receiver: long hold-off on request, otherwise random stall
  always @(negedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one request beat, idling first at random; return at the next falling edge
  task automatic send_req(input logic op, input logic [spor_pkg::SLOT_PORT_W-1:0] slot);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_slot_in <= slot;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Random phase: bursts with an allocate-heavy, mixed or release-heavy bias
  task automatic random_phase(input int count, input int s_idle, input int r_idle,
                              input int hold_at);
    int   left;
    int   burst;
    int   alloc_pct;
    logic op;
    send_idle = s_idle;
    recv_idle = r_idle;
    left      = count;
    while (left > 0) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: alloc_pct = 90;
        1: alloc_pct = 55;
        default: alloc_pct = 25;
      endcase
      while (burst > 0 && left > 0) begin
        if (left == hold_at)
          hold_req++;
        op = ($urandom_range(0, 99) < alloc_pct) ? spor_pkg::OP_ALLOC : spor_pkg::OP_RELEASE;
        send_req(op, spor_pkg::SLOT_PORT_W'($urandom_range(0, POOL - 1)));
        burst--;
        left--;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: release on an empty pool, fill it, reclaim the oldest twice
    send_req(spor_pkg::OP_RELEASE, 4'd5);
    for (int i = 0; i < POOL; i++)
      send_req(spor_pkg::OP_ALLOC, (i % 2) ? 4'hF : 4'h0);
    send_req(spor_pkg::OP_ALLOC, 4'hA);
    send_req(spor_pkg::OP_ALLOC, 4'h5);
    // Release the head, a middle entry, the tail, then an unlisted slot
    send_req(spor_pkg::OP_RELEASE, 4'd2);
    send_req(spor_pkg::OP_RELEASE, 4'd9);
    send_req(spor_pkg::OP_RELEASE, 4'd1);
    send_req(spor_pkg::OP_RELEASE, 4'd9);
    // Refill the holes lowest first, then reclaim again
    send_req(spor_pkg::OP_ALLOC, 4'h0);
    send_req(spor_pkg::OP_ALLOC, 4'hF);
    send_req(spor_pkg::OP_ALLOC, 4'h0);
    send_req(spor_pkg::OP_ALLOC, 4'hF);

    random_phase(PHASE_ITEMS, 30, 50, PHASE_ITEMS - 200);
    random_phase(PHASE_ITEMS, 50, 30, 0);
    random_phase(PHASE_ITEMS, 0, 0, PHASE_ITEMS / 2);
    in_valid <= 1'b0;

    // Drain every expected grant, then let the block settle
    while (pending != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d request beats across three idling mixes and two output hold-offs;",
             beats_sent);
    $display("saw %0d oldest-slot reclaims and %0d releases of listed slots.",
             recycle_seen, release_hits);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
